// ===== sv/gba_pkg.sv =====
// Shared types, constants and codes for the grouped bitmap allocator.
`default_nettype none
package gba_pkg;
    localparam int GROUPS = 4;
    localparam int BITS_PER_GROUP = 8192;
    localparam int WORD_BITS = 32;
    localparam int WORDS_PER_GROUP = (BITS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_DEPTH = GROUPS * WORDS_PER_GROUP;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int GBIT_W = $clog2(BITS_PER_GROUP);
    localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WIDX_W = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_FIND = 2'd1;
    localparam logic [1:0] OP_MARK = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_UNITS = 1'b0;
    localparam logic REG_GROUPS = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;   // latch the input item
        logic       div_start; // start the unit divider
        logic       div_step;  // one divider step
        logic       rd_mark;   // read word addressed by the mark
        logic       wr_mark;   // write back the flipped word
        logic       scan_clr;  // reset the scan counter
        logic       scan_rd;   // read the word at the scan counter
        logic       scan_adv;  // step the scan counter
        logic       load_wr;   // write a loaded word
        logic [1:0] res_status;
        logic       res_found; // take the found index as result
        logic       res_load;  // load the result register
    } gba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       div_done;
        logic       mark_range; // mark target outside the live groups or the group bits
        logic       word_zero;  // scanned word holds a free bit
        logic       scan_last;  // scan at last live word
    } gba_stat_t;
endpackage
`default_nettype wire

// ===== sv/gba_datapath.sv =====
// Datapath of the allocator: bitmap memory, divider, scan counter and result.
`default_nettype none
module gba_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gba_pkg::gba_cmd_t   cmd,
    output gba_pkg::gba_stat_t       stat,
    input  wire logic [1:0]          in_op,
    input  wire logic [9:0]          in_addr,
    input  wire logic [31:0]         in_data,
    input  wire logic [14:0]         in_unit,
    input  wire logic [13:0]         units_per_group,
    input  wire logic [2:0]          group_count,
    output logic [1:0]               res_status,
    output logic [14:0]              res_index
);
    import gba_pkg::*;

    logic [WORD_BITS-1:0] mem [STORE_DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [1:0]  op_reg;
    logic [9:0]  addr_reg;
    logic [31:0] data_reg;

    // Restoring divider: remainder and quotient of the unit number.
    logic [14:0] quo_reg, quo_next;
    logic [14:0] rem_reg, rem_next;
    logic [13:0] dvs_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] trial;

    logic [ADDR_W-1:0] scan_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] mark_addr;
    logic [2:0]        live;
    logic [ADDR_W:0]   scan_end;
    logic              range_bad;

    logic [1:0]  res_status_reg;
    logic [14:0] res_index_reg;
    logic [BIT_W-1:0] zbit;
    logic [GRP_W-1:0] scan_grp;
    logic [GBIT_W-1:0] gbit;
    logic [29:0] prod;

    function automatic logic [13:0] dvs_or_units();
        return (units_per_group == 14'd0) ? 14'd1 : units_per_group;
    endfunction

    assign live = (group_count > 3'(GROUPS)) ? 3'(GROUPS) : group_count;
    assign scan_end = (ADDR_W + 1)'(live) * (ADDR_W + 1)'(WORDS_PER_GROUP);

    assign trial = {rem_reg, quo_reg[14]} - {2'b0, dvs_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            rem_next = '0;
            quo_next = in_unit;
            cnt_next = 4'd15;
        end
        else if (cmd.div_step && cnt_reg != 4'd0)
        begin
            cnt_next = cnt_reg - 4'd1;
            if (!trial[15])
            begin
                rem_next = trial[14:0];
                quo_next = {quo_reg[13:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[13:0], quo_reg[14]};
                quo_next = {quo_reg[13:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.div_start)
            dvs_reg <= (units_per_group == 14'd0) ? 14'd1 : units_per_group;
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            addr_reg <= in_addr;
            data_reg <= in_data;
        end
    end

    // Quotient here is the group, remainder the bit within it.
    assign range_bad = (quo_reg >= 15'(live)) || (rem_reg >= 15'(BITS_PER_GROUP));
    assign mark_addr = ADDR_W'(quo_reg[GRP_W-1:0] * WORDS_PER_GROUP)
                     + ADDR_W'(rem_reg[GBIT_W-1:BIT_W]);
    assign rd_addr = cmd.scan_rd ? scan_reg : mark_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd || cmd.rd_mark)
            rd_data_reg <= mem[rd_addr];
        if (cmd.load_wr)
            mem[addr_reg[ADDR_W-1:0]] <= data_reg;
        else if (cmd.wr_mark)
            mem[mark_addr] <= rd_data_reg ^ (WORD_BITS'(1) << rem_reg[BIT_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= '0;
        else if (cmd.scan_clr)
            scan_reg <= '0;
        else if (cmd.scan_adv)
            scan_reg <= scan_reg + ADDR_W'(1);
    end

    // The word in rd_data_reg was read at scan_reg - 1 when a scan is in flight.
    logic [ADDR_W-1:0] prev_addr;
    assign prev_addr = scan_reg - ADDR_W'(1);

    always_comb
    begin
        zbit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
            if (!rd_data_reg[i])
                zbit = BIT_W'(i);
    end

    assign scan_grp = GRP_W'(prev_addr / WORDS_PER_GROUP);
    assign gbit = GBIT_W'({prev_addr % WORDS_PER_GROUP, zbit});
    assign prod = 30'(dvs_or_units()) * 30'(scan_grp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_status_reg <= ST_OK;
            res_index_reg  <= '0;
        end
        else if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_index_reg  <= cmd.res_found ? 15'(prod + 30'(gbit)) : 15'd0;
        end
    end

    assign stat.op         = op_reg;
    assign stat.div_done   = (cnt_reg == 4'd0);
    assign stat.mark_range = range_bad;
    assign stat.word_zero  = ~&rd_data_reg;
    assign stat.scan_last  = ({1'b0, scan_reg} + (ADDR_W + 1)'(1) >= scan_end);
    assign res_status = res_status_reg;
    assign res_index  = res_index_reg;
endmodule
`default_nettype wire

// ===== sv/gba_ctrl.sv =====
// Controller state machine sequencing load, find and mark transactions.
`default_nettype none
module gba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               out_fire,
    input  wire logic [2:0]         group_count,
    output logic                    busy,
    output logic                    res_valid,
    output gba_pkg::gba_cmd_t       cmd,
    input  wire gba_pkg::gba_stat_t stat
);
    import gba_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.res_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture   = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.scan_clr = 1'b1;
                if (stat.op == OP_LOAD)
                begin
                    cmd.load_wr  = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = S_OUT;
                end
                else if (stat.op == OP_FIND)
                begin
                    if (group_count == 3'd0)
                    begin
                        cmd.res_status = ST_NONE;
                        cmd.res_load   = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                        state_next = S_SCAN;
                end
                else if (stat.op == OP_MARK)
                begin
                    cmd.div_step = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.mark_range)
                    begin
                        cmd.res_status = ST_RANGE;
                        cmd.res_load   = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.rd_mark = 1'b1;
                        state_next  = S_MRD;
                    end
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_MRD:
            begin
                cmd.wr_mark  = 1'b1;
                cmd.res_load = 1'b1;
                state_next   = S_OUT;
            end
            S_SCAN:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.scan_adv = 1'b1;
                last_next    = stat.scan_last;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                // One word is checked while the next is read.
                if (stat.word_zero)
                begin
                    cmd.res_found = 1'b1;
                    cmd.res_load  = 1'b1;
                    state_next    = S_OUT;
                end
                else if (last_reg)
                begin
                    cmd.res_status = ST_NONE;
                    cmd.res_load   = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.scan_rd  = 1'b1;
                    cmd.scan_adv = 1'b1;
                    last_next    = stat.scan_last;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> state_reg == S_OUT)
        else $error("result loaded without presenting it");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.capture)
        else $error("item captured while busy");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_fire) |=> res_valid)
        else $error("result dropped before transaction");
endmodule
`default_nettype wire

// ===== sv/grouped_bitmap_allocator.sv =====
// Top level of the grouped bitmap allocator.
// One item at a time. A mark runs a 15-step bit-serial divider, then a read and
// write of the bitmap memory. A find reads one bitmap word per cycle from the
// single memory port, up to the first word with a free bit: at most 1024 words
// for four groups. A find with no groups in use reads no word.
// The bitmap memory is not cleared at reset; words must be loaded before use.
`default_nettype none
module grouped_bitmap_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // op[1:0], word_addr[11:2], word_data[43:12], unit_number[58:44]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // status[1:0], free_index[16:2]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import gba_pkg::*;

    gba_cmd_t  cmd;
    gba_stat_t stat;
    logic        busy;
    logic [13:0] units_reg;
    logic [2:0]  groups_reg;
    logic [1:0]  res_status;
    logic [14:0] res_index;

    assign s_tready  = !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg  <= 14'd8192;
            groups_reg <= 3'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index[0])
                REG_UNITS:  units_reg  <= cfg_data[13:0];
                REG_GROUPS: groups_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    gba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (s_tvalid && s_tready),
        .out_fire    (m_tvalid && m_tready),
        .group_count (groups_reg),
        .busy        (busy),
        .res_valid   (m_tvalid),
        .cmd         (cmd),
        .stat        (stat)
    );

    gba_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tdata[1:0]),
        .in_addr         (s_tdata[11:2]),
        .in_data         (s_tdata[43:12]),
        .in_unit         (s_tdata[58:44]),
        .units_per_group (units_reg),
        .group_count     (groups_reg),
        .res_status      (res_status),
        .res_index       (res_index)
    );

    assign m_tdata = {7'd0, res_index, res_status};
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the grouped bitmap allocator.
`default_nettype none
module tb;
    import gba_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  addr;
        logic [31:0] data;
        logic [14:0] unit;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] index;
    } alloc_rsp_t;

    localparam logic [1:0] OP_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    alloc_req_t  pending_q[$];
    alloc_rsp_t  expected_q[$];
    alloc_req_t  offered_req;
    logic [31:0] bitmap_words [0:STORE_DEPTH-1];
    logic        loaded_words [0:STORE_DEPTH-1];
    logic [13:0] units_per_group;
    logic [2:0]  group_count;
    int          send_idle;
    int          recv_idle;
    logic        rx_hold;
    int          error_count;

    grouped_bitmap_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one item to the shadow bitmap and returns the allocator's answer.
    function automatic alloc_rsp_t allocate(alloc_req_t req);
        alloc_rsp_t rsp;
        int         live;
        int         divisor;
        int         grp;
        int         pos;
        int         w;
        int         b;
        logic [31:0] word;
        rsp.status = ST_OK;
        rsp.index = '0;
        live = (group_count > GROUPS) ? GROUPS : group_count;
        divisor = (units_per_group == 0) ? 1 : units_per_group;
        if (req.op == OP_LOAD)
        begin
            bitmap_words[req.addr] = req.data;
            loaded_words[req.addr] = 1'b1;
        end
        else if (req.op == OP_FIND)
        begin
            rsp.status = ST_NONE;
            for (grp = 0; grp < live && rsp.status == ST_NONE; grp++)
            begin
                for (w = 0; w < WORDS_PER_GROUP && rsp.status == ST_NONE; w++)
                begin
                    word = bitmap_words[grp * WORDS_PER_GROUP + w];
                    for (b = 0; b < WORD_BITS && rsp.status == ST_NONE; b++)
                    begin
                        if (!word[b])
                        begin
                            pos = w * WORD_BITS + b + divisor * grp;
                            rsp.status = ST_OK;
                            rsp.index = pos[14:0];
                        end
                    end
                end
            end
        end
        else if (req.op == OP_MARK)
        begin
            grp = req.unit / divisor;
            pos = req.unit % divisor;
            if (grp >= live || pos >= BITS_PER_GROUP)
                rsp.status = ST_RANGE;
            else
                bitmap_words[grp * WORDS_PER_GROUP + pos / WORD_BITS][pos % WORD_BITS] ^= 1'b1;
        end
        return rsp;
    endfunction

    // Address of a never-loaded word that the item would read, or -1 if none.
    function automatic int unloaded_hit(alloc_req_t req);
        int live;
        int divisor;
        int grp;
        int pos;
        live = (group_count > GROUPS) ? GROUPS : group_count;
        divisor = (units_per_group == 0) ? 1 : units_per_group;
        if (req.op == OP_FIND)
        begin
            for (int a = 0; a < live * WORDS_PER_GROUP; a++)
            begin
                if (!loaded_words[a])
                    return a;
                if (bitmap_words[a] != 32'hFFFF_FFFF)
                    return -1;
            end
        end
        else if (req.op == OP_MARK)
        begin
            grp = req.unit / divisor;
            pos = req.unit % divisor;
            if (grp < live && pos < BITS_PER_GROUP
                && !loaded_words[grp * WORDS_PER_GROUP + pos / WORD_BITS])
                return grp * WORDS_PER_GROUP + pos / WORD_BITS;
        end
        return -1;
    endfunction

    // Sender: a new transaction is offered only once the previous one has gone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                offered_req = pending_q.pop_front();
                s_tdata <= {5'd0, offered_req.unit, offered_req.data,
                            offered_req.addr, offered_req.op};
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle);
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tdata[1:0], want.status));
                if (m_tdata[16:2] !== want.index)
                    report_mismatch($sformatf("free_index %0d, expected %0d",
                                              m_tdata[16:2], want.index));
            end
        end
    end

    // Items are predicted in queue order; an item that would read a word never
    // loaded is turned into a load of that word.
    task automatic push_item(input logic [1:0] op, input int addr, input logic [31:0] data,
                             input int unit);
        alloc_req_t req;
        int         gap;
        req.op = op;
        req.addr = addr[9:0];
        req.data = data;
        req.unit = unit[14:0];
        gap = unloaded_hit(req);
        if (gap >= 0)
        begin
            req.op = OP_LOAD;
            req.addr = gap[9:0];
            req.data = $urandom;
        end
        pending_q.insert(pending_q.size(), req);
        expected_q.insert(expected_q.size(), allocate(req));
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_UNITS)
            units_per_group = value[13:0];
        else
            group_count = value[2:0];
    endtask

    function automatic logic [31:0] random_word();
        int pick;
        logic [31:0] word;
        pick = $urandom_range(9);
        word = 32'hFFFF_FFFF;
        if (pick < 4)
            word[$urandom_range(31)] = 1'b0;
        else if (pick < 7)
            word = $urandom;
        return word;
    endfunction

    task automatic push_random(input int count);
        int pick;
        int span;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            span = ((units_per_group == 0) ? 1 : units_per_group) * 5;
            if (pick < 40)
                push_item(OP_LOAD, $urandom_range(1023), random_word(), $urandom);
            else if (pick < 65)
                push_item(OP_FIND, $urandom, $urandom, $urandom);
            else if (pick < 85)
                push_item(OP_MARK, $urandom, $urandom,
                          $urandom_range((span > 32767) ? 32767 : span));
            else if (pick < 95)
                push_item(OP_MARK, $urandom, $urandom, $urandom_range(32767));
            else
                push_item(OP_SPARE, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        int upg_set[6];
        int grp_set[6];
        error_count = 0;
        for (int a = 0; a < STORE_DEPTH; a++)
            loaded_words[a] = 1'b0;
        units_per_group = 14'd8192;
        group_count = 3'd4;
        send_idle <= 13;
        recv_idle <= 48;
        rx_hold <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Group zero is filled completely, the other groups only at their start.
        for (int a = 0; a < WORDS_PER_GROUP; a++)
            push_item(OP_LOAD, a, 32'hFFFF_FFFF, 0);
        for (int g = 1; g < GROUPS; g++)
            for (int a = 0; a < 16; a++)
                push_item(OP_LOAD, g * WORDS_PER_GROUP + a,
                          ($urandom_range(3) == 0) ? $urandom : 32'hFFFF_FFFF, 0);
        wait_drained();

        // Whole group zero set: a find with one live group finds nothing.
        write_reg(REG_GROUPS, 32'd1);
        push_item(OP_FIND, 0, 0, 0);
        wait_drained();
        write_reg(REG_GROUPS, 32'd4);

        // Directed corners.
        push_item(OP_LOAD, 1023, 32'h0000_0000, 32767);
        push_item(OP_LOAD, 0, 32'hFFFF_FFFE, 0);
        push_item(OP_FIND, 1023, 32'hFFFF_FFFF, 32767);
        push_item(OP_MARK, 0, 0, 0);
        push_item(OP_FIND, 0, 0, 0);
        push_item(OP_MARK, 0, 0, 0);
        push_item(OP_MARK, 0, 0, 32767);
        push_item(OP_MARK, 0, 0, 8191);
        push_item(OP_SPARE, 1023, 32'hFFFF_FFFF, 32767);
        wait_drained();
        write_reg(REG_GROUPS, 32'd7);
        write_reg(REG_UNITS, 32'd16383);
        push_item(OP_LOAD, 256, 32'hFFFF_FFFF, 0);
        push_item(OP_FIND, 0, 0, 0);
        push_item(OP_MARK, 0, 0, 9000);
        push_item(OP_MARK, 0, 0, 32766);
        wait_drained();
        write_reg(REG_GROUPS, 32'd0);
        write_reg(REG_UNITS, 32'd0);
        push_item(OP_FIND, 0, 0, 0);
        push_item(OP_MARK, 0, 0, 0);
        wait_drained();

        upg_set = '{8192, 1, 16383, 0, 100, 8192};
        grp_set = '{4, 1, 7, 0, 2, 4};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle <= 48;
                recv_idle <= 13;
            end
            else if (ph == 4)
            begin
                send_idle <= 0;
                recv_idle <= 0;
            end
            write_reg(REG_UNITS, upg_set[ph]);
            write_reg(REG_GROUPS, grp_set[ph]);
            push_random(45);
            if (ph == 1)
            begin
                // Results are held back while the sender keeps offering.
                rx_hold <= 1'b1;
                repeat (300) @(posedge clk);
                rx_hold <= 1'b0;
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/gba_pkg.sv
sv/gba_datapath.sv
sv/gba_ctrl.sv
sv/grouped_bitmap_allocator.sv
tb/tb.sv
